// ===== hw/rtl/lru_keyed_cache_slot_policy_macros.svh =====
// assertion macros for the keyed lru cache
`ifndef LRU_KEYED_CACHE_SLOT_POLICY_MACROS_SVH
`define LRU_KEYED_CACHE_SLOT_POLICY_MACROS_SVH

// same-cycle implication under reset
`define LRUKC_ASSERT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("lru cache assertion failed");

// next-cycle implication under reset
`define LRUKC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("lru cache assertion failed");

`endif

// ===== hw/rtl/lrukc_pkg.sv =====
package lrukc_pkg;

  localparam int unsigned ENTRIES  = 64;
  localparam int unsigned KEY_BITS = 64;
  localparam int unsigned IDX_W    = $clog2(ENTRIES);
  localparam int unsigned LINK_W   = IDX_W + 1;

  // link value that marks no slot
  localparam logic [LINK_W-1:0] NONE_SLOT = LINK_W'(ENTRIES);

  localparam int unsigned CFG_W  = 7;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned IN_W   = 64;
  localparam int unsigned OUT_W  = 72;

endpackage

// ===== hw/rtl/lrukc_ram.sv =====
module lrukc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== hw/rtl/lru_keyed_cache_slot_policy.sv =====
// flow: accept, a key scan of one slot per cycle up to the hit slot or the last
//   filled slot, then link update states and the output register
// a new lookup is accepted only in idle, once the previous result has been registered
// reset: control, counters and recency ends cleared; key and link memories are not
//   cleared, the filled count keeps unwritten slots from being read
`include "lru_keyed_cache_slot_policy_macros.svh"
module lru_keyed_cache_slot_policy (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lrukc_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // lookup_key
  input  logic [lrukc_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // hit, slot, evicted, hit_total, miss_total
  output logic [lrukc_pkg::OUT_W-1:0]   m_axis_tdata
);
  import lrukc_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_LRD  = 3'd2;
  localparam logic [2:0] ST_LUNL = 3'd3;
  localparam logic [2:0] ST_APP1 = 3'd4;
  localparam logic [2:0] ST_APP2 = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]          state_q, state_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [LINK_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]    slot_q, slot_d;
  logic                hit_q, hit_d, evict_q, evict_d, fill_q, fill_d;
  logic [LINK_W-1:0]   oldest_q, oldest_d, newest_q, newest_d, filled_q, filled_d;
  logic [CNT_W-1:0]    hit_cnt_q, hit_cnt_d, miss_cnt_q, miss_cnt_d;
  logic [CFG_W-1:0]    cfg_q;
  logic                out_valid_q, out_valid_d;
  logic [OUT_W-1:0]    out_data_q, out_data_d;

  logic [LINK_W-1:0]   limit;
  logic                in_acc, match, last;

  logic                key_we;
  logic [IDX_W-1:0]    key_raddr;
  logic [KEY_BITS-1:0] key_rdata;
  logic                old_we, new_we;
  logic [IDX_W-1:0]    old_waddr, new_waddr;
  logic [LINK_W-1:0]   old_wdata, new_wdata, old_rdata, new_rdata;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // active count clamped into 1..ENTRIES
  always_comb begin
    if (cfg_q == '0) begin
      limit = LINK_W'(1);
    end else if (LINK_W'(cfg_q) > LINK_W'(ENTRIES)) begin
      limit = LINK_W'(ENTRIES);
    end else begin
      limit = LINK_W'(cfg_q);
    end
  end

  // key scan compare
  assign match     = (idx_q < filled_q) && (key_rdata == key_q);
  assign last      = ((idx_q + LINK_W'(1)) >= filled_q);
  assign key_raddr = (state_q == ST_IDLE) ? '0 : IDX_W'(idx_q + LINK_W'(1));
  assign key_we    = (state_q == ST_APP1) && !hit_q;

  lrukc_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (slot_q),
    .wdata_i (key_q),
    .raddr_i (key_raddr),
    .rdata_o (key_rdata)
  );

  lrukc_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (old_we),
    .waddr_i (old_waddr),
    .wdata_i (old_wdata),
    .raddr_i (slot_q),
    .rdata_o (old_rdata)
  );

  lrukc_ram #(.WIDTH(LINK_W), .DEPTH(ENTRIES)) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (new_we),
    .waddr_i (new_waddr),
    .wdata_i (new_wdata),
    .raddr_i (slot_q),
    .rdata_o (new_rdata)
  );

  // sequencer
  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    idx_d       = idx_q;
    slot_d      = slot_q;
    hit_d       = hit_q;
    evict_d     = evict_q;
    fill_d      = fill_q;
    oldest_d    = oldest_q;
    newest_d    = newest_q;
    filled_d    = filled_q;
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    old_we      = 1'b0;
    new_we      = 1'b0;
    old_waddr   = slot_q;
    new_waddr   = slot_q;
    old_wdata   = NONE_SLOT;
    new_wdata   = NONE_SLOT;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          key_d   = s_axis_tdata[KEY_BITS-1:0];
          idx_d   = '0;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + LINK_W'(1);
        if (match) begin
          hit_d   = 1'b1;
          evict_d = 1'b0;
          fill_d  = 1'b0;
          slot_d  = idx_q[IDX_W-1:0];
          state_d = (idx_q == newest_q) ? ST_FIN : ST_LRD;
        end else if (last) begin
          hit_d = 1'b0;
          if (filled_q < limit) begin
            fill_d  = 1'b1;
            evict_d = 1'b0;
            slot_d  = filled_q[IDX_W-1:0];
            state_d = ST_APP1;
          end else begin
            fill_d  = 1'b0;
            evict_d = 1'b1;
            slot_d  = oldest_q[IDX_W-1:0];
            state_d = ST_LRD;
          end
        end
      end
      ST_LRD: begin
        state_d = ST_LUNL;
      end
      ST_LUNL: begin
        // unlink the slot from its neighbors
        if (old_rdata != NONE_SLOT) begin
          new_we    = 1'b1;
          new_waddr = old_rdata[IDX_W-1:0];
          new_wdata = new_rdata;
        end else begin
          oldest_d = new_rdata;
        end
        if (new_rdata != NONE_SLOT) begin
          old_we    = 1'b1;
          old_waddr = new_rdata[IDX_W-1:0];
          old_wdata = old_rdata;
        end else begin
          newest_d = old_rdata;
        end
        state_d = ST_APP1;
      end
      ST_APP1: begin
        // own links of the appended slot
        old_we    = 1'b1;
        old_wdata = newest_q;
        new_we    = 1'b1;
        new_wdata = NONE_SLOT;
        if (fill_q) begin
          filled_d = filled_q + LINK_W'(1);
        end
        state_d = ST_APP2;
      end
      ST_APP2: begin
        // hook onto the newest end
        if (newest_q != NONE_SLOT) begin
          new_we    = 1'b1;
          new_waddr = newest_q[IDX_W-1:0];
          new_wdata = {1'b0, slot_q};
        end else begin
          oldest_d = {1'b0, slot_q};
        end
        newest_d = {1'b0, slot_q};
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          if (hit_q) begin
            if (hit_cnt_q != '1) hit_cnt_d = hit_cnt_q + CNT_W'(1);
          end else begin
            if (miss_cnt_q != '1) miss_cnt_d = miss_cnt_q + CNT_W'(1);
          end
          out_data_d  = {miss_cnt_d, hit_cnt_d, evict_q, slot_q, hit_q};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      oldest_q    <= NONE_SLOT;
      newest_q    <= NONE_SLOT;
      filled_q    <= '0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      cfg_q       <= CFG_W'(ENTRIES);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      oldest_q    <= oldest_d;
      newest_q    <= newest_d;
      filled_q    <= filled_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    idx_q      <= idx_d;
    slot_q     <= slot_d;
    hit_q      <= hit_d;
    evict_q    <= evict_d;
    fill_q     <= fill_d;
    out_data_q <= out_data_d;
  end

  `LRUKC_ASSERT(a_fill_range, clk_i, rst_ni, 1'b1, filled_q <= LINK_W'(ENTRIES))
  `LRUKC_ASSERT(a_ends_agree, clk_i, rst_ni, 1'b1, (oldest_q == NONE_SLOT) == (newest_q == NONE_SLOT))
  `LRUKC_ASSERT(a_empty_list, clk_i, rst_ni, filled_q == '0, newest_q == NONE_SLOT)
  `LRUKC_ASSERT(a_hit_no_evict, clk_i, rst_ni, state_q == ST_FIN, !(hit_q && evict_q))
  `LRUKC_ASSERT_NEXT(a_accept_scan, clk_i, rst_ni, in_acc, state_q == ST_SCAN)

endmodule

// ===== tb/lru_keyed_cache_slot_policy_checker.sv =====
`timescale 1ns / 100ps
module lru_keyed_cache_slot_policy_checker
  import lrukc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  // lookup_key
  input  logic [IN_W-1:0]    s_axis_tdata,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // hit, slot, evicted, hit_total, miss_total
  input  logic [OUT_W-1:0]   m_axis_tdata,
  output int                 fail_count_o,
  output int                 pending_count_o
);

  // result word, first field in the highest bits
  typedef struct packed {
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] hit_total;
    logic             evicted;
    logic [IDX_W-1:0] slot;
    logic             hit;
  } lookup_result_t;

  lookup_result_t expected_results[$];

  // shadow of the cache state
  logic [KEY_BITS-1:0] shadow_keys [ENTRIES];
  logic [LINK_W-1:0]   shadow_older[ENTRIES];
  logic [LINK_W-1:0]   shadow_newer[ENTRIES];
  logic [LINK_W-1:0]   lru_end, mru_end;
  int unsigned         filled_slots;
  logic [CNT_W-1:0]    hits_seen, misses_seen;
  logic [CFG_W-1:0]    slots_in_use;

  function automatic void detach_slot(int unsigned s);
    logic [LINK_W-1:0] o;
    logic [LINK_W-1:0] n;
    o = shadow_older[s];
    n = shadow_newer[s];
    if (o != NONE_SLOT) shadow_newer[o] = n;
    else lru_end = n;
    if (n != NONE_SLOT) shadow_older[n] = o;
    else mru_end = o;
    shadow_older[s] = NONE_SLOT;
    shadow_newer[s] = NONE_SLOT;
  endfunction

  function automatic void make_newest(int unsigned s);
    shadow_older[s] = mru_end;
    shadow_newer[s] = NONE_SLOT;
    if (mru_end != NONE_SLOT) shadow_newer[mru_end] = LINK_W'(s);
    else lru_end = LINK_W'(s);
    mru_end = LINK_W'(s);
  endfunction

  function automatic lookup_result_t predict_lookup(logic [KEY_BITS-1:0] key);
    lookup_result_t r;
    int unsigned lim;
    int unsigned s;
    bit found;
    r = '0;
    found = 0;
    s = 0;
    lim = (slots_in_use == 0) ? 1 : (slots_in_use > ENTRIES) ? ENTRIES : slots_in_use;
    for (int unsigned i = 0; i < filled_slots; i++) begin
      if (!found && shadow_keys[i] == key) begin
        found = 1;
        s = i;
      end
    end
    if (found) begin
      r.hit = 1'b1;
      if (hits_seen != '1) hits_seen++;
      if (LINK_W'(s) != mru_end) begin
        detach_slot(s);
        make_newest(s);
      end
    end else begin
      if (misses_seen != '1) misses_seen++;
      if (filled_slots < lim) begin
        s = filled_slots;
        filled_slots++;
        make_newest(s);
      end else begin
        s = (lru_end == NONE_SLOT) ? 0 : lru_end;
        r.evicted = 1'b1;
        detach_slot(s);
        make_newest(s);
      end
      shadow_keys[s] = key;
    end
    r.slot       = IDX_W'(s);
    r.hit_total  = hits_seen;
    r.miss_total = misses_seen;
    return r;
  endfunction

  // track config, predict on accepted lookups, compare on accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t got, want;
    if (!rst_ni) begin
      lru_end      = NONE_SLOT;
      mru_end      = NONE_SLOT;
      filled_slots = 0;
      hits_seen    = '0;
      misses_seen  = '0;
      slots_in_use = CFG_W'(ENTRIES);
      fail_count_o = 0;
      pending_count_o <= 0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) slots_in_use = cfg_wdata_i;
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_results.size() == 0) begin
          $error("result word with nothing expected: %h", m_axis_tdata);
          fail_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (got.hit !== want.hit) begin
            $error("hit: expected %0d actual %0d", want.hit, got.hit);
            fail_count_o++;
          end
          if (got.slot !== want.slot) begin
            $error("slot: expected %0d actual %0d", want.slot, got.slot);
            fail_count_o++;
          end
          if (got.evicted !== want.evicted) begin
            $error("evicted: expected %0d actual %0d", want.evicted, got.evicted);
            fail_count_o++;
          end
          if (got.hit_total !== want.hit_total) begin
            $error("hit_total: expected %0d actual %0d", want.hit_total, got.hit_total);
            fail_count_o++;
          end
          if (got.miss_total !== want.miss_total) begin
            $error("miss_total: expected %0d actual %0d", want.miss_total, got.miss_total);
            fail_count_o++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_results.push_back(predict_lookup(s_axis_tdata[KEY_BITS-1:0]));
      pending_count_o <= expected_results.size();
    end
  end

endmodule

// ===== tb/lru_keyed_cache_slot_policy_test.sv =====
`timescale 1ns / 100ps
module lru_keyed_cache_slot_policy_test;
  import lrukc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1500000;
  localparam int unsigned DRAIN_CYCLES = 80;

  typedef enum int {NO_IDLE, SEND_IDLE, RECV_STALL, BOTH_IDLE} idle_mode_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  int               fail_count, pending_count;
  int unsigned      cycle_count = 0;
  idle_mode_t       idle_mode = NO_IDLE;
  logic [IN_W-1:0]  key_pool[96];

  always #5 clk_i = ~clk_i;

  lru_keyed_cache_slot_policy dut (.*);

  lru_keyed_cache_slot_policy_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver stalls
  always @(negedge clk_i) begin
    case (idle_mode)
      RECV_STALL: m_axis_tready <= ($urandom_range(99) >= 70);
      BOTH_IDLE:  m_axis_tready <= ($urandom_range(99) >= 15);
      default:    m_axis_tready <= 1'b1;
    endcase
  end

  // one lookup word; called at a falling edge, returns at a falling edge
  task automatic send_key(logic [IN_W-1:0] key);
    int unsigned pct;
    pct = (idle_mode == SEND_IDLE) ? 70 : (idle_mode == BOTH_IDLE) ? 15 : 0;
    if ($urandom_range(99) < pct) begin
      s_axis_tvalid = 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < pct);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = key;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_active(logic [CFG_W-1:0] value);
    wait_drained();
    cfg_we_i    = 1'b1;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  // random lookups, mostly reused keys so hits and evictions happen
  task automatic random_lookups(int unsigned count, int unsigned pool_size);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 75)
        send_key(key_pool[$urandom_range(pool_size - 1)]);
      else
        send_key({$urandom, $urandom});
    end
  endtask

  initial begin
    logic [CFG_W-1:0] settings[10];
    settings = '{7'd4, 7'd1, 7'd0, 7'd127, 7'd2, 7'd64, 7'd8, 7'd3, 7'd65, 7'd16};
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extremes, repeat of newest, hit of an older slot, eviction
    write_active(7'd3);
    send_key('0);
    send_key('1);
    send_key('1);
    send_key('0);
    send_key(64'h8000_0000_0000_0001);
    send_key(64'h5555_5555_5555_5555);
    send_key('1);
    send_key(64'h8000_0000_0000_0001);
    send_key(64'hAAAA_AAAA_AAAA_AAAA);
    // lower below the filled count: misses evict, upper slots still hit
    write_active(7'd1);
    send_key(64'h8000_0000_0000_0001);
    send_key(64'hAAAA_AAAA_AAAA_AAAA);
    send_key(64'h0123_4567_89AB_CDEF);
    send_key(64'h0123_4567_89AB_CDEF);

    // random phases over several settings and idle modes
    for (int p = 0; p < 16; p++) begin
      logic [CFG_W-1:0] value;
      value = (p < 10) ? settings[p] : CFG_W'($urandom_range(127));
      write_active(value);
      idle_mode = idle_mode_t'(p % 4);
      random_lookups((value > 32 && value < 66) ? 50 : 95,
                     (value == 0) ? 2 : (value > 48) ? 96 : value + value / 2 + 1);
    end

    idle_mode = NO_IDLE;
    wait_drained();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lrukc_pkg.sv
hw/rtl/lrukc_ram.sv
hw/rtl/lru_keyed_cache_slot_policy.sv
tb/lru_keyed_cache_slot_policy_checker.sv
tb/lru_keyed_cache_slot_policy_test.sv
